[rtl/afvt_pkg.sv]
// ----------------------------------------------------------------------------
// afvt_pkg
// Types, constants and helper functions of the flow ACL verdict table.
// ----------------------------------------------------------------------------
package afvt_pkg;

    localparam int BUCKET_BITS = 10;
    localparam int WAYS        = 4;
    localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int NBUCKETS    = 1 << BUCKET_BITS;
    localparam int HASH_MULT   = 31;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);
    localparam int NPROBES     = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HASH_SEED    = 1'd1;

    // Actions
    localparam logic [1:0] ACT_CHECK  = 2'd0;
    localparam logic [1:0] ACT_ADD    = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;
    localparam logic [1:0] ACT_FLUSH  = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DROP     = 3'd1;
    localparam logic [2:0] ST_EXISTS   = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    // Default modes
    localparam logic [1:0] MODE_DENY_ALL = 2'd2;

    typedef logic [BUCKET_BITS-1:0] t_bkt;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] src_port_min;
        logic [15:0] src_port_max;
        logic [15:0] dst_port_min;
        logic [15:0] dst_port_max;
        logic        rule_deny;
        logic [23:0] conn_limit;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic        rule_hit;
        logic [31:0] permitted_count;
        logic [31:0] denied_count;
    } t_out_item;

    // Classified command: item plus the three probe buckets
    typedef struct packed {
        t_in_item                item;
        logic [NPROBES-1:0][BUCKET_BITS-1:0] bkt;
    } t_cmd;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [63:0] port_bounds;
        logic        is_deny;
        logic [23:0] conn_cap;
        logic [31:0] permit_count;
        logic [31:0] deny_count;
    } t_entry;

    typedef struct packed {
        logic [WAYS-1:0]         valid;
        t_entry [WAYS-1:0]       ent;
    } t_row;

    // Seeded bucket hash; both addresses zero map to bucket 0
    function automatic t_bkt bucket_hash(logic [31:0] s, logic [31:0] d,
                                         logic [31:0] seed);
        logic [31:0] h;
        h = s * 32'(HASH_MULT * HASH_MULT) + d * 32'(HASH_MULT) + seed;
        if (s == 32'd0 && d == 32'd0) begin
            return '0;
        end
        return h[BUCKET_BITS-1:0];
    endfunction

    function automatic logic port_ok(logic [15:0] p, logic [15:0] lo, logic [15:0] hi);
        if (lo > hi) begin
            return 1'b0;
        end
        if (hi != 16'd0 && (p < lo || p > hi)) begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic rule_match(t_entry e, logic [31:0] s, logic [31:0] d,
                                        logic [15:0] sp, logic [15:0] dp);
        logic ok;
        ok = (e.src_addr == 32'd0 || e.src_addr == s) &&
             (e.dst_addr == 32'd0 || e.dst_addr == d) &&
             port_ok(sp, e.port_bounds[15:0], e.port_bounds[31:16]) &&
             port_ok(dp, e.port_bounds[47:32], e.port_bounds[63:48]);
        return ok;
    endfunction

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

endpackage

[rtl/afvt_front.sv]
// ----------------------------------------------------------------------------
// afvt_front
// Accepts input beats and computes the three probe buckets of each item.
// ----------------------------------------------------------------------------
module afvt_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [31:0]         i_hash_seed,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  afvt_pkg::t_in_item  i_in_data,
    input  logic                i_q_full,
    output logic                o_q_push,
    output afvt_pkg::t_cmd      o_q_data
);

    logic           r_valid;
    afvt_pkg::t_cmd r_cmd;
    afvt_pkg::t_cmd n_cmd;
    logic           accept;

    // Hand the staged command to the queue whenever it has room
    assign o_q_push   = r_valid && !i_q_full;
    assign o_in_stall = r_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_q_data   = r_cmd;

    // Classify: both addresses, source only, destination only
    always_comb begin
        n_cmd        = r_cmd;
        n_cmd.item   = i_in_data;
        n_cmd.bkt[0] = afvt_pkg::bucket_hash(i_in_data.src_addr, i_in_data.dst_addr,
                                             i_hash_seed);
        n_cmd.bkt[1] = afvt_pkg::bucket_hash(i_in_data.src_addr, 32'd0, i_hash_seed);
        n_cmd.bkt[2] = afvt_pkg::bucket_hash(32'd0, i_in_data.dst_addr, i_hash_seed);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

[rtl/afvt_queue.sv]
// ----------------------------------------------------------------------------
// afvt_queue
// Short command queue between the front and the table engine.
// ----------------------------------------------------------------------------
module afvt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  afvt_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output afvt_pkg::t_cmd o_data
);

    afvt_pkg::t_cmd                   r_mem [afvt_pkg::QDEPTH];
    logic [afvt_pkg::QPTR_W-1:0]      r_wp;
    logic [afvt_pkg::QPTR_W-1:0]      r_rp;
    logic [afvt_pkg::QCNT_W-1:0]      r_cnt;

    assign o_full  = (r_cnt == afvt_pkg::QCNT_W'(afvt_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

[rtl/afvt_engine.sv]
// ----------------------------------------------------------------------------
// afvt_engine
// Rule table memory and the sequencer that runs check, add, delete and flush.
// ----------------------------------------------------------------------------
module afvt_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [1:0]           i_default_mode,
    input  logic                 i_q_empty,
    input  afvt_pkg::t_cmd       i_q_data,
    output logic                 o_q_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output afvt_pkg::t_out_item  o_out_data
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_EVAL  = 4'b1000
    } t_state;

    afvt_pkg::t_row        r_mem [afvt_pkg::NBUCKETS];
    afvt_pkg::t_row        r_rd_row;
    t_state                r_state, n_state;
    afvt_pkg::t_cmd        r_cmd;
    logic [1:0]            r_probe, n_probe;
    afvt_pkg::t_bkt        r_clr;
    logic                  r_out_valid;
    afvt_pkg::t_out_item   r_out, n_out;
    logic                  out_load;
    logic                  out_free;

    logic                  mem_we;
    afvt_pkg::t_bkt        mem_waddr;
    afvt_pkg::t_row        mem_wrow;
    afvt_pkg::t_bkt        rd_addr;

    afvt_pkg::t_in_item    it;
    afvt_pkg::t_entry      new_ent;
    logic [63:0]           bounds;
    logic                  found;
    logic [afvt_pkg::WAY_W-1:0] hit_way;
    logic                  add_exists;
    logic                  add_free;
    afvt_pkg::t_entry      he;
    logic                  permit;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign it          = r_cmd.item;
    assign bounds      = {it.dst_port_max, it.dst_port_min, it.src_port_max, it.src_port_min};
    assign rd_addr     = r_cmd.bkt[r_probe];

    // Pop a flush only when its result can be posted at once
    assign o_q_pop = (r_state == S_IDLE) && !i_q_empty &&
                     (i_q_data.item.action != afvt_pkg::ACT_FLUSH || out_free);

    // Rule being added
    always_comb begin
        new_ent.src_addr     = it.src_addr;
        new_ent.dst_addr     = it.dst_addr;
        new_ent.port_bounds  = bounds;
        new_ent.is_deny      = it.rule_deny;
        new_ent.conn_cap     = it.conn_limit;
        new_ent.permit_count = 32'd0;
        new_ent.deny_count   = 32'd0;
    end

    // Search the ways of the bucket just read
    always_comb begin
        found      = 1'b0;
        hit_way    = '0;
        add_exists = 1'b0;
        add_free   = 1'b0;
        for (int w = 0; w < afvt_pkg::WAYS; w++) begin
            case (it.action)
                afvt_pkg::ACT_CHECK: begin
                    if (!found && r_rd_row.valid[w] &&
                        afvt_pkg::rule_match(r_rd_row.ent[w], it.src_addr, it.dst_addr,
                                             it.src_port, it.dst_port)) begin
                        found   = 1'b1;
                        hit_way = afvt_pkg::WAY_W'(w);
                    end
                end
                afvt_pkg::ACT_ADD: begin
                    if (!found) begin
                        if (!r_rd_row.valid[w]) begin
                            found    = 1'b1;
                            add_free = 1'b1;
                            hit_way  = afvt_pkg::WAY_W'(w);
                        end else if (r_rd_row.ent[w].src_addr == it.src_addr &&
                                     r_rd_row.ent[w].dst_addr == it.dst_addr) begin
                            found      = 1'b1;
                            add_exists = 1'b1;
                        end
                    end
                end
                afvt_pkg::ACT_DELETE: begin
                    if (!found && r_rd_row.valid[w] &&
                        r_rd_row.ent[w].src_addr == it.src_addr &&
                        r_rd_row.ent[w].dst_addr == it.dst_addr &&
                        r_rd_row.ent[w].port_bounds == bounds &&
                        r_rd_row.ent[w].is_deny == it.rule_deny &&
                        r_rd_row.ent[w].conn_cap == it.conn_limit) begin
                        found   = 1'b1;
                        hit_way = afvt_pkg::WAY_W'(w);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign he     = r_rd_row.ent[hit_way];
    assign permit = !he.is_deny &&
                    !(he.conn_cap != 24'd0 && he.permit_count >= {8'd0, he.conn_cap});

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_probe   = r_probe;
        n_out     = r_out;
        out_load  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = rd_addr;
        mem_wrow  = r_rd_row;
        case (r_state)
            S_CLEAR: begin
                mem_we         = 1'b1;
                mem_waddr      = r_clr;
                mem_wrow.valid = '0;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (o_q_pop) begin
                    n_probe = 2'd0;
                    if (i_q_data.item.action == afvt_pkg::ACT_FLUSH) begin
                        out_load = 1'b1;
                        n_out    = '{afvt_pkg::ST_OK, 1'b0, 32'd0, 32'd0};
                        n_state  = S_CLEAR;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (out_free) begin
                    n_state  = S_IDLE;
                    out_load = 1'b1;
                    n_out    = '{afvt_pkg::ST_OK, 1'b0, 32'd0, 32'd0};
                    case (it.action)
                        afvt_pkg::ACT_CHECK: begin
                            if (found) begin
                                n_out.rule_hit        = 1'b1;
                                n_out.permitted_count = he.permit_count;
                                n_out.denied_count    = he.deny_count;
                                if (i_default_mode != 2'd0) begin
                                    mem_we = 1'b1;
                                    if (permit) begin
                                        mem_wrow.ent[hit_way].permit_count =
                                            afvt_pkg::sat_inc(he.permit_count);
                                        n_out.permitted_count =
                                            afvt_pkg::sat_inc(he.permit_count);
                                    end else begin
                                        mem_wrow.ent[hit_way].deny_count =
                                            afvt_pkg::sat_inc(he.deny_count);
                                        n_out.denied_count =
                                            afvt_pkg::sat_inc(he.deny_count);
                                        n_out.status = afvt_pkg::ST_DROP;
                                    end
                                end
                            end else if (r_probe != 2'(afvt_pkg::NPROBES - 1)) begin
                                // Try the next bucket
                                out_load = 1'b0;
                                n_probe  = r_probe + 2'd1;
                                n_state  = S_READ;
                            end else if (i_default_mode == afvt_pkg::MODE_DENY_ALL) begin
                                n_out.status = afvt_pkg::ST_DROP;
                            end
                        end
                        afvt_pkg::ACT_ADD: begin
                            if (add_exists) begin
                                n_out.status = afvt_pkg::ST_EXISTS;
                            end else if (add_free) begin
                                mem_we                  = 1'b1;
                                mem_wrow.valid[hit_way] = 1'b1;
                                mem_wrow.ent[hit_way]   = new_ent;
                            end else begin
                                n_out.status = afvt_pkg::ST_FULL;
                            end
                        end
                        afvt_pkg::ACT_DELETE: begin
                            if (found) begin
                                // Shift later ways down by one
                                mem_we = 1'b1;
                                for (int k = 0; k < afvt_pkg::WAYS - 1; k++) begin
                                    if (afvt_pkg::WAY_W'(k) >= hit_way) begin
                                        mem_wrow.valid[k] = r_rd_row.valid[k+1];
                                        mem_wrow.ent[k]   = r_rd_row.ent[k+1];
                                    end
                                end
                                mem_wrow.valid[afvt_pkg::WAYS-1] = 1'b0;
                            end else begin
                                n_out.status = afvt_pkg::ST_NOTFOUND;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_probe     <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_probe <= n_probe;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_data;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    // Table memory: one row per bucket
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wrow;
        end
        if (r_state == S_READ) begin
            r_rd_row <= r_mem[rd_addr];
        end
    end

endmodule

[rtl/flow_acl_verdict_table_top.sv]
// ----------------------------------------------------------------------------
// flow_acl_verdict_table_top
// Hashed set-associative IPv4 ACL table with per-flow verdict.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_item)
//  cfg     | input     | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// Add and delete probe one bucket; a check probes up to three buckets in turn
// through the single table read port, stopping at the first bucket that hits.
// A flush, and reset, sweep the table one bucket row per cycle, and no item
// starts until the sweep is done. Reset is synchronous, active low.
// A queue of two commands lets the front keep taking beats while the engine
// or the output side stalls, until the queue and the front stage fill up.
// ----------------------------------------------------------------------------
module flow_acl_verdict_table_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [afvt_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [afvt_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  afvt_pkg::t_in_item                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output afvt_pkg::t_out_item                  o_out_data
);

    logic [1:0]     r_default_mode;
    logic [31:0]    r_hash_seed;
    logic           q_push, q_pop, q_full, q_empty;
    afvt_pkg::t_cmd q_in, q_out;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_mode <= 2'd0;
            r_hash_seed    <= 32'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                afvt_pkg::REG_DEFAULT_MODE: r_default_mode <= i_cfg_data[1:0];
                afvt_pkg::REG_HASH_SEED:    r_hash_seed    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    afvt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hash_seed (r_hash_seed),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_data    (q_in)
    );

    afvt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    afvt_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_default_mode (r_default_mode),
        .i_q_empty      (q_empty),
        .i_q_data       (q_out),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_data     (o_out_data)
    );

endmodule

[dv/tb_flow_acl_verdict_table_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flow_acl_verdict_table_top
// Self-checking bench for the flow ACL verdict table. A shadow copy of the
// bucketed rule table predicts the status, hit flag and counters of every
// command. Traffic mixes directed corner cases with random add, delete, check
// and flush beats. Random idling and stalling run on both channels.
// ----------------------------------------------------------------------------
module tb_flow_acl_verdict_table_top;
    import afvt_pkg::*;

    localparam int NSLOTS = NBUCKETS * WAYS;
    localparam logic [1:0] MODE_NONE       = 2'd0;
    localparam logic [1:0] MODE_PERMIT_ALL = 2'd1;
    localparam logic [1:0] MODE_ODD        = 2'd3;
    localparam int NRANDOM = 1525;

    // Shadow rule table plus the queue of verdicts still owed by the block
    class acl_verdict_sb;
        logic [1:0]  mode;
        logic [31:0] seed;
        bit          slot_used[NSLOTS];
        t_entry      slot[NSLOTS];
        t_out_item   verdict_q[$];
        int          errors;
        int          n_checks, n_hits, n_drops, n_adds, n_full, n_dels;

        function void clear_all();
            foreach (slot_used[i]) slot_used[i] = 1'b0;
        endfunction

        function logic [BUCKET_BITS-1:0] home(logic [31:0] s, logic [31:0] d);
            logic [31:0] h;
            h = (s * 32'd31 + d) * 32'd31 + seed;
            if (s == 0 && d == 0) return '0;
            return h[BUCKET_BITS-1:0];
        endfunction

        function bit port_pass(logic [15:0] p, logic [15:0] lo, logic [15:0] hi);
            if (lo > hi) return 1'b0;
            if (hi != 0 && (p < lo || p > hi)) return 1'b0;
            return 1'b1;
        endfunction

        // Slot index of the first matching way of one bucket, or -1
        function int scan(logic [BUCKET_BITS-1:0] b, t_in_item it);
            int e;
            for (int w = 0; w < WAYS; w++) begin
                e = b * WAYS + w;
                if (slot_used[e] &&
                    (slot[e].src_addr == 0 || slot[e].src_addr == it.src_addr) &&
                    (slot[e].dst_addr == 0 || slot[e].dst_addr == it.dst_addr) &&
                    port_pass(it.src_port, slot[e].port_bounds[15:0],
                              slot[e].port_bounds[31:16]) &&
                    port_pass(it.dst_port, slot[e].port_bounds[47:32],
                              slot[e].port_bounds[63:48]))
                    return e;
            end
            return -1;
        endfunction

        function logic [31:0] bump(logic [31:0] v);
            return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
        endfunction

        function void note_request(t_in_item it);
            t_out_item r;
            int m, e, w;
            logic [BUCKET_BITS-1:0] b;
            logic [63:0] bounds;
            bit permit;
            r = '0;
            bounds = {it.dst_port_max, it.dst_port_min, it.src_port_max, it.src_port_min};
            b = home(it.src_addr, it.dst_addr);
            case (it.action)
                ACT_CHECK: begin
                    n_checks++;
                    m = scan(b, it);
                    if (m < 0) m = scan(home(it.src_addr, 32'd0), it);
                    if (m < 0) m = scan(home(32'd0, it.dst_addr), it);
                    if (m >= 0) begin
                        n_hits++;
                        r.rule_hit = 1'b1;
                        r.status = ST_OK;
                        if (mode != MODE_NONE) begin
                            permit = !slot[m].is_deny && !(slot[m].conn_cap != 0 &&
                                     slot[m].permit_count >= 32'(slot[m].conn_cap));
                            if (permit) begin
                                slot[m].permit_count = bump(slot[m].permit_count);
                            end else begin
                                slot[m].deny_count = bump(slot[m].deny_count);
                                r.status = ST_DROP;
                            end
                        end
                        r.permitted_count = slot[m].permit_count;
                        r.denied_count = slot[m].deny_count;
                    end else begin
                        r.status = (mode == MODE_DENY_ALL) ? ST_DROP : ST_OK;
                    end
                    if (r.status == ST_DROP) n_drops++;
                end
                ACT_ADD: begin
                    r.status = ST_FULL;
                    for (w = 0; w < WAYS; w++) begin
                        e = b * WAYS + w;
                        if (!slot_used[e]) break;
                        if (slot[e].src_addr == it.src_addr &&
                            slot[e].dst_addr == it.dst_addr) begin
                            r.status = ST_EXISTS;
                            break;
                        end
                    end
                    if (r.status != ST_EXISTS && w < WAYS) begin
                        e = b * WAYS + w;
                        slot_used[e] = 1'b1;
                        slot[e] = '{it.src_addr, it.dst_addr, bounds, it.rule_deny,
                                    it.conn_limit, 32'd0, 32'd0};
                        r.status = ST_OK;
                        n_adds++;
                    end
                    if (r.status == ST_FULL) n_full++;
                end
                ACT_DELETE: begin
                    r.status = ST_NOTFOUND;
                    for (w = 0; w < WAYS; w++) begin
                        e = b * WAYS + w;
                        if (slot_used[e] && slot[e].src_addr == it.src_addr &&
                            slot[e].dst_addr == it.dst_addr &&
                            slot[e].port_bounds == bounds &&
                            slot[e].is_deny == it.rule_deny &&
                            slot[e].conn_cap == it.conn_limit) begin
                            // shift later ways down to keep the bucket packed
                            for (int k = w; k + 1 < WAYS; k++) begin
                                slot_used[b * WAYS + k] = slot_used[b * WAYS + k + 1];
                                slot[b * WAYS + k] = slot[b * WAYS + k + 1];
                            end
                            slot_used[b * WAYS + WAYS - 1] = 1'b0;
                            r.status = ST_OK;
                            n_dels++;
                            break;
                        end
                    end
                end
                default: clear_all();
            endcase
            verdict_q.push_back(r);
        endfunction

        function void check_verdict(t_out_item got);
            t_out_item want;
            if (verdict_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat %h", $time, got);
                return;
            end
            want = verdict_q.pop_front();
            if (got.status !== want.status) begin
                errors++;
                $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
            end
            if (got.rule_hit !== want.rule_hit) begin
                errors++;
                $display("%0t: rule_hit exp %0d got %0d", $time, want.rule_hit,
                         got.rule_hit);
            end
            if (got.permitted_count !== want.permitted_count) begin
                errors++;
                $display("%0t: permitted_count exp %0d got %0d", $time,
                         want.permitted_count, got.permitted_count);
            end
            if (got.denied_count !== want.denied_count) begin
                errors++;
                $display("%0t: denied_count exp %0d got %0d", $time,
                         want.denied_count, got.denied_count);
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;

    acl_verdict_sb sb = new();
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;
    logic [31:0] pool_s[8];
    logic [31:0] pool_d[8];
    logic [31:0] crowd_s, crowd_d;
    t_in_item    rules[$];

    flow_acl_verdict_table_top uut (.*);

    always #5 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver: random stall, with one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            i_out_stall <= 1'b1;
            repeat (300) @(posedge i_clk);
            hold_req <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(99) < 38);
        end
    end

    // Check every accepted result beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_verdict(o_out_data);
    end

    task automatic send(t_in_item it);
        while (!quiet && $urandom_range(99) < 38) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(it);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.verdict_q.size() != 0) @(posedge i_clk);
    endtask

    // Write one register once the table is idle, including any flush sweep
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        drain();
        repeat (1100) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_DEFAULT_MODE) sb.mode = val[1:0];
        else sb.seed = val;
    endtask

    function automatic t_in_item rule(logic [1:0] act, logic [31:0] s, logic [31:0] d,
                                      logic [15:0] smin, logic [15:0] smax,
                                      logic [15:0] dmin, logic [15:0] dmax,
                                      logic deny, logic [23:0] cap);
        t_in_item it;
        it = '0;
        it.action = act;
        it.src_addr = s;
        it.dst_addr = d;
        it.src_port_min = smin;
        it.src_port_max = smax;
        it.dst_port_min = dmin;
        it.dst_port_max = dmax;
        it.rule_deny = deny;
        it.conn_limit = cap;
        return it;
    endfunction

    function automatic t_in_item flow(logic [31:0] s, logic [31:0] d,
                                      logic [15:0] sp, logic [15:0] dp);
        t_in_item it;
        it = '0;
        it.action = ACT_CHECK;
        it.src_addr = s;
        it.dst_addr = d;
        it.src_port = sp;
        it.dst_port = dp;
        return it;
    endfunction

    // Random command, mostly aimed at a small set of address pairs
    function automatic t_in_item pick_item();
        t_in_item it;
        int k, r;
        logic [31:0] s, d;
        logic [15:0] lo;
        logic [191:0] raw;
        k = $urandom_range(13);
        if (k < 8) begin
            s = pool_s[k];
            d = pool_d[k];
        end else begin
            // same-bucket group: a step of 1024 in the destination keeps the hash
            s = crowd_s;
            d = crowd_d + 32'((k - 8) * 1024);
        end
        r = $urandom_range(99);
        if ($urandom_range(299) == 0) begin
            it = '0;
            it.action = ACT_FLUSH;
        end else if (r < 5) begin
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            it = raw[$bits(t_in_item)-1:0];
            if (it.action == ACT_FLUSH) it.action = ACT_CHECK;
        end else if (r < 30) begin
            lo = 16'($urandom_range(40));
            it = rule(ACT_ADD, s, d, lo, 16'(0), 16'($urandom_range(40)), 16'(0),
                      1'($urandom_range(1)), ($urandom_range(1) ? 24'd0
                                                           : 24'($urandom_range(1, 3))));
            if ($urandom_range(3) != 0) it.src_port_max = lo + 16'($urandom_range(40));
            if ($urandom_range(9) == 0) it.src_port_max = lo - 16'd1;
            if ($urandom_range(3) != 0)
                it.dst_port_max = it.dst_port_min + 16'($urandom_range(40));
            if ($urandom_range(19) == 0) it.conn_limit = 24'($urandom);
            rules.push_back(it);
            if (rules.size() > 64) void'(rules.pop_front());
        end else if (r < 42 && rules.size() != 0) begin
            it = rules[$urandom_range(rules.size() - 1)];
            it.action = ACT_DELETE;
            if ($urandom_range(3) == 0) it.conn_limit ^= 24'd1;
        end else begin
            if (s == 0) s = $urandom_range(1) ? pool_s[$urandom_range(7)] : $urandom;
            if (d == 0) d = $urandom_range(1) ? pool_d[$urandom_range(7)] : $urandom;
            it = flow(s, d, 16'($urandom_range(90)), 16'($urandom_range(90)));
            if ($urandom_range(19) == 0) it.src_port = 16'($urandom);
        end
        return it;
    endfunction

    initial begin
        logic [1:0]  modes[6];
        logic [31:0] seeds[6];
        modes = '{MODE_PERMIT_ALL, MODE_DENY_ALL, MODE_NONE,
                  MODE_ODD, MODE_DENY_ALL, MODE_PERMIT_ALL};
        sb.mode = MODE_NONE;
        sb.seed = '0;
        sb.clear_all();
        seeds = '{32'd0, 32'hFFFF_FFFF, $urandom, $urandom, $urandom, 32'hFFFF_FFFF};
        foreach (pool_s[i]) begin
            pool_s[i] = (i == 1 || i == 2) ? 32'd0 : $urandom;
            pool_d[i] = (i == 3 || i == 2) ? 32'd0 : $urandom;
        end
        pool_d[1] = 32'hFFFF_FFFF;
        crowd_s = $urandom;
        crowd_d = $urandom;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(REG_DEFAULT_MODE, 32'(MODE_DENY_ALL));
        write_reg(REG_HASH_SEED, 32'h1234_5678);

        // Directed: duplicates, full bucket, wildcards, port edges, caps, deletes
        send(rule(ACT_ADD, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 24'd0));
        send(rule(ACT_ADD, 32'd0, 32'd0, 16'd5, 16'd9, 16'd0, 16'd0, 1'b1, 24'd0));
        send(flow(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        for (int k = 0; k < 5; k++)
            send(rule(ACT_ADD, crowd_s, crowd_d + 32'(k * 1024), 16'd10, 16'd20,
                      16'd0, 16'hFFFF, k[0], 24'(k == 2)));
        send(flow(crowd_s, crowd_d, 16'd10, 16'd0));
        send(flow(crowd_s, crowd_d, 16'd21, 16'd0));
        send(flow(crowd_s, crowd_d + 32'd2048, 16'd20, 16'hFFFF));
        send(flow(crowd_s, crowd_d + 32'd2048, 16'd20, 16'hFFFF));
        send(flow(crowd_s, crowd_d + 32'd1024, 16'd15, 16'd7));
        send(rule(ACT_DELETE, crowd_s, crowd_d, 16'd10, 16'd20, 16'd0, 16'hFFFF,
                  1'b0, 24'd0));
        send(rule(ACT_DELETE, crowd_s, crowd_d, 16'd10, 16'd20, 16'd0, 16'hFFFF,
                  1'b0, 24'd0));
        send(rule(ACT_ADD, pool_s[0], 32'd0, 16'd30, 16'd2, 16'd0, 16'd0, 1'b0, 24'd0));
        send(flow(pool_s[0], 32'h0A00_0001, 16'd30, 16'd1));
        send(rule(ACT_ADD, 32'd0, pool_d[0], 16'hFFFF, 16'hFFFF, 16'd0, 16'd0,
                  1'b0, 24'hFF_FFFF));
        send(flow(32'h0A00_0002, pool_d[0], 16'hFFFF, 16'd3));
        send(flow(32'h0A00_0002, 32'h0B00_0003, 16'd1, 16'd2));
        send(rule(ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 16'hFFFF, 16'hFFFF,
                  16'd0, 1'b1, 24'hFF_FFFF));
        send(flow(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 16'hFFFF));
        send(rule(ACT_FLUSH, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 24'd0));
        send(flow(crowd_s, crowd_d + 32'd2048, 16'd20, 16'hFFFF));

        // Random phases across register settings
        for (int p = 0; p < 6; p++) begin
            write_reg(REG_DEFAULT_MODE, 32'(modes[p]));
            write_reg(REG_HASH_SEED, seeds[p]);
            for (int n = 0; n < NRANDOM / 6; n++) begin
                if (p == 1 && n == 50) hold_req = 1'b1;
                if (p == 2 && n == 100) drain();
                quiet = (p == 3 && n >= 40 && n < 200);
                send(pick_item());
            end
        end
        quiet = 1'b0;
        drain();
        repeat (1200) @(posedge i_clk);

        $display("Covered %0d checks (%0d hits, %0d drops), %0d adds, %0d full, %0d deletes",
                 sb.n_checks, sb.n_hits, sb.n_drops, sb.n_adds, sb.n_full, sb.n_dels);
        $display("across six mode/seed settings with random stalls on both channels");
        if (sb.errors == 0 && sb.verdict_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
